// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the angle unwrap block.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that post holds in the cycle after pre.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- hdl/lau_pkg.sv -----
// Constants and widths for the lidar angle unwrap and timestamp block.
// No dependencies; imported by lidar_angle_unwrap_timestamp.
`timescale 1ns / 1ps

package lau_pkg;

    localparam int ANGLE_FRAC_BITS = 16;

    // field widths
    localparam int PITCH_W  = 16;
    localparam int YAW_W    = 17;
    localparam int SIDE_W   = 8;
    localparam int THETA_W  = 18;
    localparam int PHI_W    = 32;
    localparam int TS_W     = 64;
    localparam int CENTER_W = 63;

    // port widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 9;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - THETA_W - PHI_W - TS_W;
    localparam int CFG_W     = 64;

    // beam side codes
    localparam logic [SIDE_W-1:0] SIDE_A = 8'd0;
    localparam logic [SIDE_W-1:0] SIDE_B = 8'd1;

    // angles in degrees Q8, signed working width
    localparam int DEG_W = 19;
    localparam logic signed [DEG_W-1:0] HALF_TURN_Q8 = DEG_W'(46080);
    localparam logic signed [DEG_W-1:0] FULL_TURN_Q8 = DEG_W'(92160);

    // pi in Q40 and in the output format
    localparam int PI_CONST_W = 42;
    localparam logic [PI_CONST_W-1:0] PI_Q40 = 42'h3243F6A8886;
    localparam int PI_SHIFT = 40 - ANGLE_FRAC_BITS;
    localparam logic [63:0] PI_QF_64 =
        (64'(PI_Q40) + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;
    localparam logic [63:0] TWO_PI_QF_64 =
        ((64'(PI_Q40) << 1) + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;

    // unwrap arithmetic width
    localparam int UNW_W = PHI_W + 2;
    localparam logic signed [UNW_W-1:0] PI_QF      = UNW_W'(PI_QF_64);
    localparam logic signed [UNW_W-1:0] NEG_PI_QF  = -PI_QF;
    localparam logic signed [UNW_W-1:0] TWO_PI_QF  = UNW_W'(TWO_PI_QF_64);
    localparam logic signed [UNW_W-1:0] PHI_MAX    =
        UNW_W'((64'd1 << (PHI_W - 1)) - 64'd1);
    localparam logic signed [UNW_W-1:0] PHI_MIN    = ~PHI_MAX;

    // degree to radian: round(mag * PI_Q40 / (180 << DEN_SH))
    localparam int MAG_W    = 18;
    localparam int PROD_W   = MAG_W + PI_CONST_W;
    localparam int DEN_SH   = 48 - ANGLE_FRAC_BITS;
    localparam int HALF_DIV = 90;
    localparam int T_W      = PROD_W - DEN_SH + 1;
    localparam int RECIP_SH = T_W + 8;
    localparam int RECIP_W  = T_W + 1;
    localparam logic [63:0] RECIP_180_64 = ((64'd1 << RECIP_SH) + 64'd179) / 64'd180;
    localparam logic [RECIP_W-1:0] RECIP_180 = RECIP_W'(RECIP_180_64);
    localparam int QP_W = T_W + RECIP_W;
    localparam int Q_W  = T_W - 7;

    // time offset: trunc(mag * 78125 / 36) by reciprocal
    localparam int TMAG_W  = 17;
    localparam int TIME_SH = 22;
    localparam int TIME_RECIP_W = 34;
    localparam logic [63:0] TIME_RECIP_64 = ((64'd78125 << TIME_SH) + 64'd35) / 64'd36;
    localparam logic [TIME_RECIP_W-1:0] TIME_RECIP = TIME_RECIP_W'(TIME_RECIP_64);
    localparam int TPROD_W = TMAG_W + TIME_RECIP_W;
    localparam int TOFF_W  = TPROD_W - TIME_SH;

endpackage

// ----- hdl/lidar_angle_unwrap_timestamp.sv -----
// Lidar angle converter with per-side azimuth unwrap and point timestamps.
// Depends on lau_pkg and assert_macros.svh.
// A result word passes level 1, level 2, level 3 and the result register to reach m_tvalid.
// Throughput: one word per cycle while m_tready is high; four register levels each stall only when full.
// The unwrap stage reads and writes the per-side azimuth state in the same cycle,
// so back-to-back points of the same side unwrap against each other.
// Reset (aresetn low, synchronous): pipeline empty, seen marks, last azimuths
// and scan center time cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lidar_angle_unwrap_timestamp import lau_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // pitch_deg_q8[15:0], yaw_deg_q8[32:16], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,    // side_code[7:0], scan_start[8]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // theta_rad_q16[17:0], phi_rad_q16[49:18],
                                             // timestamp_ns[113:50], zero pad
    output logic [M_TUSER_W-1:0] m_tuser,    // bad_side[0]
    // scan center time writes
    input  logic                 cfg_tvalid,
    output logic                 cfg_tready,
    input  logic [CFG_W-1:0]     cfg_tdata   // scan_center_time_ns[62:0], unused [63]
);

    // ---------------------------------------------------------------------
    // Stall chain: a level loads when empty or when the level after it moves.
    // ---------------------------------------------------------------------
    logic en1, en2, en3, en_out;

    logic v1_reg, v2_reg, v3_reg, out_v_reg;

    assign en_out   = !out_v_reg || m_tready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign cfg_tready = 1'b1;

    // ---------------------------------------------------------------------
    // Level 1: captured input word
    // ---------------------------------------------------------------------
    logic signed [PITCH_W-1:0] pitch1_reg;
    logic signed [YAW_W-1:0]   yaw1_reg;
    logic [SIDE_W-1:0]         side1_reg;
    logic                      start1_reg;

    logic                      bad_next2, side_b_next2;
    logic signed [DEG_W-1:0]   pitch_ext, yaw_ext, phi_deg, t_deg;
    logic signed [DEG_W-1:0]   pitch_abs, phi_abs_deg, t_abs;
    logic                      th_neg_next, ph_neg_next, t_neg_next;
    logic [PROD_W-1:0]         prod_th_next, prod_ph_next;
    logic [TPROD_W-1:0]        tprod_next;

    always_comb begin
        bad_next2    = (side1_reg != SIDE_A) && (side1_reg != SIDE_B);
        side_b_next2 = (side1_reg == SIDE_B);

        pitch_ext = DEG_W'(pitch1_reg);
        yaw_ext   = DEG_W'(yaw1_reg);

        // side B sits one full turn further round
        phi_deg = side_b_next2 ? yaw_ext + FULL_TURN_Q8 : yaw_ext;

        // side B time reference is shifted half a turn: down for positive yaw, up otherwise
        if (!side_b_next2) begin
            t_deg = yaw_ext;
        end else if (yaw_ext > 0) begin
            t_deg = yaw_ext - HALF_TURN_Q8;
        end else begin
            t_deg = yaw_ext + HALF_TURN_Q8;
        end

        th_neg_next = pitch_ext[DEG_W-1];
        ph_neg_next = phi_deg[DEG_W-1];
        t_neg_next  = t_deg[DEG_W-1];

        pitch_abs   = th_neg_next ? -pitch_ext : pitch_ext;
        phi_abs_deg = ph_neg_next ? -phi_deg : phi_deg;
        t_abs       = t_neg_next ? -t_deg : t_deg;

        prod_th_next = PROD_W'(pitch_abs[MAG_W-1:0]) * PROD_W'(PI_Q40);
        prod_ph_next = PROD_W'(phi_abs_deg[MAG_W-1:0]) * PROD_W'(PI_Q40);
        tprod_next   = TPROD_W'(t_abs[TMAG_W-1:0]) * TPROD_W'(TIME_RECIP);
    end

    // ---------------------------------------------------------------------
    // Level 2: products; divide by 180 through the reciprocal
    // ---------------------------------------------------------------------
    logic                bad2_reg, side_b2_reg, start2_reg;
    logic                th_neg2_reg, ph_neg2_reg, t_neg2_reg;
    logic [PROD_W-1:0]   prod_th2_reg, prod_ph2_reg;
    logic [TPROD_W-1:0]  tprod2_reg;

    logic [T_W-1:0]      t_th, t_ph;
    logic [QP_W-1:0]     qprod_th, qprod_ph;
    logic [Q_W-1:0]      q_th_next, q_ph_next;
    logic [TOFF_W-1:0]   toff_mag_next;

    always_comb begin
        // rounding half of the denominator folds into a plain +90
        t_th = T_W'(prod_th2_reg >> DEN_SH) + T_W'(HALF_DIV);
        t_ph = T_W'(prod_ph2_reg >> DEN_SH) + T_W'(HALF_DIV);

        qprod_th = QP_W'(t_th) * QP_W'(RECIP_180);
        qprod_ph = QP_W'(t_ph) * QP_W'(RECIP_180);

        q_th_next     = Q_W'(qprod_th >> RECIP_SH);
        q_ph_next     = Q_W'(qprod_ph >> RECIP_SH);
        toff_mag_next = TOFF_W'(tprod2_reg >> TIME_SH);
    end

    // ---------------------------------------------------------------------
    // Level 3: magnitudes; unwrap and timestamp feed the result register
    // ---------------------------------------------------------------------
    logic                bad3_reg, side_b3_reg, start3_reg;
    logic                th_neg3_reg, ph_neg3_reg, t_neg3_reg;
    logic [Q_W-1:0]      q_th3_reg, q_ph3_reg;
    logic [TOFF_W-1:0]   toff_mag3_reg;

    logic signed [PHI_W-1:0] last_phi0_reg, last_phi1_reg;
    logic                    seen0_reg, seen1_reg;
    logic [CENTER_W-1:0]     center_reg;

    logic signed [Q_W:0]       th_abs, th_val;
    logic signed [UNW_W-1:0]   phi_abs, phi_cv, last_ext, diff, phi_adj;
    logic signed [TS_W-1:0]    toff_abs, toff_s;
    logic                      seen_sel;

    logic [THETA_W-1:0]        theta_next;
    logic signed [PHI_W-1:0]   phi_next;
    logic [TS_W-1:0]           ts_next;

    logic                      upd;
    logic                      seen0_next, seen1_next;
    logic signed [PHI_W-1:0]   last_phi0_next, last_phi1_next;

    always_comb begin
        th_abs = signed'((Q_W + 1)'(q_th3_reg));
        th_val = th_neg3_reg ? -th_abs : th_abs;

        phi_abs  = signed'(UNW_W'(q_ph3_reg));
        phi_cv   = ph_neg3_reg ? -phi_abs : phi_abs;
        last_ext = side_b3_reg ? UNW_W'(last_phi1_reg) : UNW_W'(last_phi0_reg);
        // scan start drops both seen marks before this point
        seen_sel = !start3_reg && (side_b3_reg ? seen1_reg : seen0_reg);
        diff     = phi_cv - last_ext;

        // unwrap by at most one turn
        if (seen_sel && (diff > PI_QF)) begin
            phi_adj = phi_cv - TWO_PI_QF;
        end else if (seen_sel && (diff < NEG_PI_QF)) begin
            phi_adj = phi_cv + TWO_PI_QF;
        end else begin
            phi_adj = phi_cv;
        end

        // saturate to the output range
        if (phi_adj > PHI_MAX) begin
            phi_next = PHI_W'(PHI_MAX);
        end else if (phi_adj < PHI_MIN) begin
            phi_next = PHI_W'(PHI_MIN);
        end else begin
            phi_next = PHI_W'(phi_adj);
        end

        toff_abs = signed'(TS_W'(toff_mag3_reg));
        toff_s   = t_neg3_reg ? -toff_abs : toff_abs;
        // wraps modulo 2^64
        ts_next  = TS_W'(center_reg) + unsigned'(toff_s);

        theta_next = th_val[THETA_W-1:0];

        // a bad side clears the payload
        if (bad3_reg) begin
            theta_next = '0;
            phi_next   = '0;
            ts_next    = '0;
        end

        // state update on a good point entering the result register
        upd            = en_out && v3_reg && !bad3_reg;
        seen0_next     = seen0_reg;
        seen1_next     = seen1_reg;
        last_phi0_next = last_phi0_reg;
        last_phi1_next = last_phi1_reg;
        if (upd) begin
            if (start3_reg) begin
                seen0_next = 1'b0;
                seen1_next = 1'b0;
            end
            if (side_b3_reg) begin
                seen1_next     = 1'b1;
                last_phi1_next = phi_next;
            end else begin
                seen0_next     = 1'b1;
                last_phi0_next = phi_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    logic [THETA_W-1:0]      theta_reg;
    logic signed [PHI_W-1:0] phi_reg;
    logic [TS_W-1:0]         ts_reg;
    logic                    bad_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {M_PAD_W'(0), ts_reg, phi_reg, theta_reg};
    assign m_tuser  = M_TUSER_W'(bad_reg);

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_v_reg     <= 1'b0;
            seen0_reg     <= 1'b0;
            seen1_reg     <= 1'b0;
            last_phi0_reg <= '0;
            last_phi1_reg <= '0;
            center_reg    <= '0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en_out) begin
                out_v_reg <= v3_reg;
            end
            seen0_reg     <= seen0_next;
            seen1_reg     <= seen1_next;
            last_phi0_reg <= last_phi0_next;
            last_phi1_reg <= last_phi1_next;
            if (cfg_tvalid) begin
                center_reg <= cfg_tdata[CENTER_W-1:0];
            end
        end
    end

    // payload: advance with the stall chain, no reset
    always_ff @(posedge aclk) begin
        if (en1) begin
            pitch1_reg <= signed'(s_tdata[PITCH_W-1:0]);
            yaw1_reg   <= signed'(s_tdata[PITCH_W+YAW_W-1:PITCH_W]);
            side1_reg  <= s_tuser[SIDE_W-1:0];
            start1_reg <= s_tuser[SIDE_W];
        end
        if (en2) begin
            bad2_reg     <= bad_next2;
            side_b2_reg  <= side_b_next2;
            start2_reg   <= start1_reg;
            th_neg2_reg  <= th_neg_next;
            ph_neg2_reg  <= ph_neg_next;
            t_neg2_reg   <= t_neg_next;
            prod_th2_reg <= prod_th_next;
            prod_ph2_reg <= prod_ph_next;
            tprod2_reg   <= tprod_next;
        end
        if (en3) begin
            bad3_reg      <= bad2_reg;
            side_b3_reg   <= side_b2_reg;
            start3_reg    <= start2_reg;
            th_neg3_reg   <= th_neg2_reg;
            ph_neg3_reg   <= ph_neg2_reg;
            t_neg3_reg    <= t_neg2_reg;
            q_th3_reg     <= q_th_next;
            q_ph3_reg     <= q_ph_next;
            toff_mag3_reg <= toff_mag_next;
        end
        if (en_out) begin
            theta_reg <= theta_next;
            phi_reg   <= phi_next;
            ts_reg    <= ts_next;
            bad_reg   <= bad3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a bad-side word carries an all-zero payload
    `ASSERT_PROP(a_bad_zero, aclk, aresetn, m_tvalid && bad_reg |-> theta_reg == '0 && phi_reg == '0 && ts_reg == '0)
    // a bad-side word leaves the unwrap state alone
    `ASSERT_NEXT(a_bad_keeps_state, aclk, aresetn, en_out && v3_reg && bad3_reg, $stable(last_phi0_reg) && $stable(last_phi1_reg) && $stable(seen0_reg) && $stable(seen1_reg))
    // a good side A word leaves its azimuth as the side A reference
    `ASSERT_NEXT(a_side_a_ref, aclk, aresetn, en_out && v3_reg && !bad3_reg && !side_b3_reg, seen0_reg && last_phi0_reg == phi_reg)
    // input stalls only with every level full and the output blocked
    `ASSERT_PROP(a_stall_full, aclk, aresetn, !s_tready |-> v1_reg && v2_reg && v3_reg && out_v_reg && !m_tready)

endmodule
